// File: sv/sasd_pkg.sv
// ----------------------------------------------------------------------------
// sasd_pkg
// Shared types, codes and field widths for the shared-array double stack.
// ----------------------------------------------------------------------------
package sasd_pkg;

   // Default number of words in the shared array
   localparam int DefaultDepth = 64;

   // Field widths
   localparam int KindW   = 2;
   localparam int PosW    = 6;
   localparam int WordW   = 32;
   localparam int StatusW = 2;
   localparam int FillW   = 7;

   // Channel widths (req: position, word_in; rsp: word_out, status, fills)
   localparam int ReqDataW = 40;
   localparam int ReqUserW = 3;
   localparam int RspDataW = 48;

   // Operation codes
   localparam logic [KindW-1:0] KindPush   = 2'd0;
   localparam logic [KindW-1:0] KindPop    = 2'd1;
   localparam logic [KindW-1:0] KindPeek   = 2'd2;
   localparam logic [KindW-1:0] KindModify = 2'd3;

   // Result status codes
   localparam logic [StatusW-1:0] StatOk     = 2'd0;
   localparam logic [StatusW-1:0] StatFull   = 2'd1;
   localparam logic [StatusW-1:0] StatEmpty  = 2'd2;
   localparam logic [StatusW-1:0] StatBadIdx = 2'd3;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;   // capture the request and read the array
      logic commit;   // apply the operation and load the result register
   } sasd_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_busy; // result register holds a transfer not taken this cycle
   } sasd_stat_type;

endpackage

// File: sv/sasd_ctrl.sv
// ----------------------------------------------------------------------------
// sasd_ctrl
// Two-state controller: takes one request, then commits it once the result
// register can take the answer.
// ----------------------------------------------------------------------------
module sasd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  sasd_pkg::sasd_stat_type stat,
   output sasd_pkg::sasd_cmd_type  cmd
);
   import sasd_pkg::*;

   localparam logic StIdle = 1'b0;
   localparam logic StExec = 1'b1;

   logic state_ff;
   logic state_in;

   // Ready only while no request is in flight
   assign req_tready = (state_ff == StIdle);
   assign cmd.accept = req_tvalid && (state_ff == StIdle);
   assign cmd.commit = (state_ff == StExec) && !stat.out_busy;

   // Advance state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (cmd.accept) state_in = StExec;
         end
         StExec: begin
            if (cmd.commit) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/sasd_dp.sv
// ----------------------------------------------------------------------------
// sasd_dp
// Datapath: shared array, both fill counts, request capture, status logic
// and the result register.
// ----------------------------------------------------------------------------
module sasd_dp #(
   parameter int DEPTH = sasd_pkg::DefaultDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sasd_pkg::sasd_cmd_type         cmd,
   output sasd_pkg::sasd_stat_type        stat,
   input  logic [sasd_pkg::ReqDataW-1:0]  req_tdata,
   input  logic [sasd_pkg::ReqUserW-1:0]  req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sasd_pkg::RspDataW-1:0]  rsp_tdata
);
   import sasd_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CmpW = (CW > PosW) ? CW : PosW;
   localparam int SumW = CmpW + 1;
   localparam logic [SumW-1:0] DepthS = SumW'(DEPTH);
   localparam logic [SumW-1:0] OneS   = SumW'(1);
   localparam logic [CW-1:0]   OneC   = CW'(1);

   logic [WordW-1:0]    mem_ram [DEPTH];
   logic [WordW-1:0]    rdata_ff;
   logic [AW-1:0]       rd_addr;

   logic [KindW-1:0]    kind_ff;
   logic                hi_ff;
   logic [PosW-1:0]     pos_ff;
   logic [WordW-1:0]    word_ff;

   logic [CW-1:0]       count_low_ff,  count_low_in;
   logic [CW-1:0]       count_high_ff, count_high_in;

   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   logic [SumW-1:0]     total;
   logic [CW-1:0]       cnt;
   logic [WordW-1:0]    data;
   logic [StatusW-1:0]  status;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;

   // Read address of the target stack's top, from the incoming request
   always_comb begin
      if (req_tuser[KindW]) begin
         rd_addr = AW'(DepthS - SumW'(count_high_ff));
      end else begin
         rd_addr = AW'(SumW'(count_low_ff) - OneS);
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_tuser[KindW-1:0];
         hi_ff   <= req_tuser[KindW];
         pos_ff  <= req_tdata[PosW-1:0];
         word_ff <= req_tdata[PosW +: WordW];
      end
   end

   // Decide status, write and count update for the held request
   always_comb begin
      total         = SumW'(count_low_ff) + SumW'(count_high_ff);
      cnt           = hi_ff ? count_high_ff : count_low_ff;
      data          = '0;
      status        = StatOk;
      wr_en         = 1'b0;
      wr_addr       = '0;
      count_low_in  = count_low_ff;
      count_high_in = count_high_ff;
      unique case (kind_ff)
         KindPush: begin
            if (total >= DepthS) begin
               status = StatFull;
            end else if (hi_ff) begin
               wr_en         = 1'b1;
               wr_addr       = AW'(DepthS - OneS - SumW'(count_high_ff));
               count_high_in = count_high_ff + OneC;
            end else begin
               wr_en        = 1'b1;
               wr_addr      = AW'(count_low_ff);
               count_low_in = count_low_ff + OneC;
            end
         end
         KindPop, KindPeek: begin
            if (cnt == '0) begin
               status = StatEmpty;
            end else begin
               data = rdata_ff;
               if (kind_ff == KindPop) begin
                  if (hi_ff) count_high_in = count_high_ff - OneC;
                  else       count_low_in  = count_low_ff - OneC;
               end
            end
         end
         KindModify: begin
            if (CmpW'(pos_ff) >= CmpW'(cnt)) begin
               status = StatBadIdx;
            end else begin
               wr_en = 1'b1;
               if (hi_ff) begin
                  wr_addr = AW'(DepthS - SumW'(count_high_ff) + SumW'(pos_ff));
               end else begin
                  wr_addr = AW'(pos_ff);
               end
            end
         end
         default: status = StatOk;
      endcase
   end

   // Shared array: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem_ram[wr_addr] <= word_ff;
      end
      if (cmd.accept) begin
         rdata_ff <= mem_ram[rd_addr];
      end
   end

   // Update fill counts
   always_ff @(posedge clock) begin
      if (reset) begin
         count_low_ff  <= '0;
         count_high_ff <= '0;
      end else if (cmd.commit) begin
         count_low_ff  <= count_low_in;
         count_high_ff <= count_high_in;
      end
   end

   // Result register: load on commit, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {FillW'(count_high_in), FillW'(count_low_in), status, data};
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

`ifndef ASSERT_OFF
   // The two stacks never hold more than the array
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (SumW'(count_low_ff) + SumW'(count_high_ff)) <= DepthS)
      else $error("stack fills exceed array depth");

   // A commit never overwrites a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten");

   // Accept and commit never fall in the same cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.commit))
      else $error("accept and commit together");

   // Counts move only on a commit
   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> ($stable(count_low_ff) && $stable(count_high_ff)))
      else $error("fill count changed without commit");

   // A successful low pop lowers the low fill by one
   a_low_pop: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && kind_ff == KindPop && !hi_ff && status == StatOk)
      |=> (count_low_ff == $past(count_low_ff) - OneC))
      else $error("low pop did not lower fill");
`endif

endmodule

// File: sv/shared_array_double_stack.sv
// Timing: the result register loads on the commit that follows the request
// transfer; the commit waits while an earlier result is still untaken.
// Flow: no new request is taken until the last one commits, since ready is
// low while a request is in flight; a stalled result port holds it in flight.
// Reset: synchronous, clears both fill counts and the result valid; the
// array contents are not cleared and are only read after being written.
// ----------------------------------------------------------------------------
// shared_array_double_stack
// Two stacks in one array: the low stack grows up from entry 0, the high
// stack grows down from the last entry. Push, pop, peek and modify.
// ----------------------------------------------------------------------------
module shared_array_double_stack #(
   parameter int DEPTH = sasd_pkg::DefaultDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [5:0] position, [37:6] word_in, [39:38] zero
   input  logic [sasd_pkg::ReqDataW-1:0] req_tdata,
   // [1:0] kind, [2] which_stack
   input  logic [sasd_pkg::ReqUserW-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] word_out, [33:32] status, [40:34] fill_low, [47:41] fill_high
   output logic [sasd_pkg::RspDataW-1:0] rsp_tdata
);
   import sasd_pkg::*;

   sasd_cmd_type  cmd;
   sasd_stat_type stat;

   sasd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sasd_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: dv/sasd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sasd_checker
// Watches the request and result channels of the shared-array double stack.
// Keeps its own copy of the two stacks, works out the result of each request
// transfer, and compares each result transfer against the oldest one owed.
// ----------------------------------------------------------------------------
module sasd_checker #(
   parameter int DEPTH = sasd_pkg::DefaultDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   // [5:0] position, [37:6] word_in, [39:38] zero
   input  logic [sasd_pkg::ReqDataW-1:0] req_tdata,
   // [1:0] kind, [2] which_stack
   input  logic [sasd_pkg::ReqUserW-1:0] req_tuser,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] word_out, [33:32] status, [40:34] fill_low, [47:41] fill_high
   input  logic [sasd_pkg::RspDataW-1:0] rsp_tdata,
   output int                            mismatch_count,
   output int                            results_owed
);
   import sasd_pkg::*;

   // Laid out in the same bit order as rsp_tdata
   typedef struct packed {
      logic [FillW-1:0]   fill_high;
      logic [FillW-1:0]   fill_low;
      logic [StatusW-1:0] status;
      logic [WordW-1:0]   word_out;
   } stack_result_type;

   logic [WordW-1:0] array_copy [DEPTH];
   int unsigned      low_fill;
   int unsigned      high_fill;
   stack_result_type owed_q [$];

   // Apply one operation to the local copy of both stacks
   function automatic stack_result_type apply_stack_op(
      logic [KindW-1:0] kind,
      logic             to_high,
      logic [PosW-1:0]  pos,
      logic [WordW-1:0] word
   );
      stack_result_type res;
      int unsigned      fill;
      int unsigned      addr;
      res = '0;
      res.status = StatOk;
      fill = to_high ? high_fill : low_fill;
      case (kind)
         KindPush: begin
            if (low_fill + high_fill >= DEPTH) begin
               res.status = StatFull;
            end else if (to_high) begin
               high_fill++;
               array_copy[DEPTH - high_fill] = word;
            end else begin
               array_copy[low_fill] = word;
               low_fill++;
            end
         end
         KindPop, KindPeek: begin
            if (fill == 0) begin
               res.status = StatEmpty;
            end else begin
               addr = to_high ? DEPTH - high_fill : low_fill - 1;
               res.word_out = array_copy[addr];
               if (kind == KindPop) begin
                  if (to_high) high_fill--;
                  else low_fill--;
               end
            end
         end
         KindModify: begin
            // high stack indexes count down from its top element
            if (pos >= fill) begin
               res.status = StatBadIdx;
            end else begin
               addr = to_high ? DEPTH - high_fill + pos : pos;
               array_copy[addr] = word;
            end
         end
         default: ;
      endcase
      res.fill_low  = FillW'(low_fill);
      res.fill_high = FillW'(high_fill);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
      mismatch_count++;
      $display("%0t sasd_checker: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin : watch
      stack_result_type got;
      stack_result_type want;
      if (reset) begin
         low_fill = 0;
         high_fill = 0;
         owed_q.delete();
         mismatch_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            owed_q.push_back(apply_stack_op(req_tuser[KindW-1:0], req_tuser[KindW],
                                            req_tdata[PosW-1:0], req_tdata[PosW +: WordW]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (owed_q.size() == 0) begin
               report_mismatch("result with nothing owed", got.word_out, '0);
            end else begin
               want = owed_q.pop_front();
               if (got.word_out !== want.word_out)
                  report_mismatch("word_out", got.word_out, want.word_out);
               if (got.status !== want.status)
                  report_mismatch("status", WordW'(got.status), WordW'(want.status));
               if (got.fill_low !== want.fill_low)
                  report_mismatch("fill_low", WordW'(got.fill_low), WordW'(want.fill_low));
               if (got.fill_high !== want.fill_high)
                  report_mismatch("fill_high", WordW'(got.fill_high), WordW'(want.fill_high));
            end
         end
      end
      results_owed <= owed_q.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives push, pop, peek and modify requests into the shared-array double
// stack: a directed opening on empty and nearly empty stacks, then random
// phases that fill the array to full, drain it, and mix operations. Both
// channels stall at random; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
   import sasd_pkg::*;

   localparam int Depth      = DefaultDepth;
   localparam int IdlePct    = 18;
   localparam int HoldCycles = 80;
   localparam int StallLimit = 2000;
   localparam int ItemTarget = 1650;
   localparam int SettleWait = 10;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic [ReqUserW-1:0] req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   int   mismatch_count;
   int   results_owed;
   logic steady       = 1'b0;
   int   hold_asks    = 0;
   int   hold_seen    = 0;
   int   hold_left    = 0;
   int   stall_cycles = 0;
   int   issued       = 0;
   // fill counts used only to steer the random mix
   int   lo_fill      = 0;
   int   hi_fill      = 0;

   shared_array_double_stack #(.DEPTH(Depth)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sasd_checker #(.DEPTH(Depth)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asks != hold_seen) begin
         rsp_tready <= 1'b0;
         hold_seen  <= hold_asks;
         hold_left  <= HoldCycles;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IdlePct);
      end
   end

   // End the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one request and hold it until the transfer
   task automatic send_item(
      logic [KindW-1:0] kind,
      logic             to_high,
      logic [PosW-1:0]  pos,
      logic [WordW-1:0] word
   );
      while (!steady && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataW - WordW - PosW){1'b0}}, word, pos};
      req_tuser  <= {to_high, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      issued++;
      case (kind)
         KindPush: begin
            if (lo_fill + hi_fill < Depth) begin
               if (to_high) hi_fill++;
               else lo_fill++;
            end
         end
         KindPop: begin
            if (to_high && hi_fill > 0) hi_fill--;
            else if (!to_high && lo_fill > 0) lo_fill--;
         end
         default: ;
      endcase
   endtask

   // Mostly random words, with the extremes now and then
   function automatic logic [WordW-1:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // One random operation; modify indexes mostly land inside the fill
   task automatic random_item(int push_pct);
      logic [KindW-1:0] kind;
      logic             to_high;
      logic [PosW-1:0]  pos;
      int               fill;
      to_high = 1'($urandom_range(1));
      if ($urandom_range(99) < push_pct) begin
         kind = KindPush;
      end else begin
         case ($urandom_range(2))
            0: kind = KindPop;
            1: kind = KindPeek;
            default: kind = KindModify;
         endcase
      end
      fill = to_high ? hi_fill : lo_fill;
      if (kind == KindModify && fill > 0 && $urandom_range(9) < 8)
         pos = PosW'($urandom_range(fill - 1));
      else
         pos = PosW'($urandom_range(63));
      send_item(kind, to_high, pos, pick_word());
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   initial begin
      int   phase;
      int   push_pct;
      logic one_side;
      logic side;
      phase = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty stacks: pop, peek and modify are all refused
      send_item(KindPop,    1'b0, 6'd0,  32'h0);
      send_item(KindPeek,   1'b1, 6'd0,  32'h0);
      send_item(KindModify, 1'b0, 6'd0,  32'h1234_5678);
      send_item(KindModify, 1'b1, 6'd63, 32'hFFFF_FFFF);
      // a few pushes on each side with extreme words
      send_item(KindPush,   1'b0, 6'd63, 32'h7FFF_FFFF);
      send_item(KindPush,   1'b1, 6'd0,  32'h8000_0000);
      send_item(KindPush,   1'b0, 6'd42, 32'hFFFF_FFFF);
      send_item(KindPush,   1'b1, 6'd21, 32'h0);
      send_item(KindPush,   1'b1, 6'd0,  32'h5A5A_A5A5);
      send_item(KindPeek,   1'b0, 6'd0,  32'h0);
      send_item(KindPeek,   1'b1, 6'd0,  32'h0);
      // modify inside and just past each fill
      send_item(KindModify, 1'b0, 6'd0,  32'hFFFF_FFFE);
      send_item(KindModify, 1'b1, 6'd1,  32'h8000_0001);
      send_item(KindModify, 1'b1, 6'd2,  32'h7FFF_FFFE);
      send_item(KindModify, 1'b1, 6'd3,  32'h1);
      send_item(KindModify, 1'b0, 6'd2,  32'h2);
      // drain both, then one more pop on each empty stack
      send_item(KindPop,    1'b0, 6'd0,  32'h0);
      send_item(KindPop,    1'b0, 6'd0,  32'h0);
      send_item(KindPop,    1'b0, 6'd0,  32'h0);
      send_item(KindPop,    1'b1, 6'd0,  32'h0);
      send_item(KindPop,    1'b1, 6'd0,  32'h0);
      send_item(KindPop,    1'b1, 6'd0,  32'h0);
      send_item(KindPop,    1'b1, 6'd0,  32'h0);
      wait_drained();

      while (issued < ItemTarget) begin
         phase++;
         if (phase == 6) steady <= 1'b1;
         if (phase == 14) steady <= 1'b0;
         if (phase == 3 || $urandom_range(15) == 0) hold_asks <= hold_asks + 1;
         case ($urandom_range(9))
            0, 1: begin
               // fill the array until the tops meet, then push into a full array
               one_side = 1'($urandom_range(1));
               side = 1'($urandom_range(1));
               while (lo_fill + hi_fill < Depth)
                  send_item(KindPush, one_side ? side : 1'($urandom_range(1)),
                            6'($urandom_range(63)), pick_word());
               repeat ($urandom_range(1, 3))
                  send_item(KindPush, 1'($urandom_range(1)), 6'($urandom_range(63)),
                            pick_word());
               repeat ($urandom_range(4, 12)) random_item(10);
            end
            2: begin
               // pop both stacks down to empty, then poke the empty stacks
               while (lo_fill + hi_fill > 0)
                  send_item(KindPop, hi_fill > 0 && (lo_fill == 0 || $urandom_range(1)),
                            6'($urandom_range(63)), pick_word());
               repeat ($urandom_range(1, 4))
                  send_item($urandom_range(1) ? KindPop : KindPeek, 1'($urandom_range(1)),
                            6'($urandom_range(63)), pick_word());
            end
            default: begin
               case ($urandom_range(2))
                  0: push_pct = 30;
                  1: push_pct = 50;
                  default: push_pct = 70;
               endcase
               repeat ($urandom_range(20, 60)) random_item(push_pct);
            end
         endcase
         if (phase == 4 || $urandom_range(4) == 0) wait_drained();
      end

      wait_drained();
      repeat (SettleWait) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
